[rtl/tspsi_pkg.sv]
`timescale 1ns / 1ps

package tspsi_pkg;

	localparam int MAX_ENTRIES  = 32;
	localparam int PACKET_BYTES = 188;

	localparam int OP_W   = 2;
	localparam int ST_W   = 8;
	localparam int PID_W  = 13;
	localparam int ENT_W  = ST_W + PID_W;
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 16;

	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
	localparam logic [OP_W-1:0] OP_PAT    = 2'd2;
	localparam logic [OP_W-1:0] OP_PMT    = 2'd3;

	localparam logic [CFG_AW-1:0] REG_TS_ID      = 3'd0;
	localparam logic [CFG_AW-1:0] REG_PROGRAM    = 3'd1;
	localparam logic [CFG_AW-1:0] REG_PMT_PID    = 3'd2;
	localparam logic [CFG_AW-1:0] REG_PCR_PID    = 3'd3;
	localparam logic [CFG_AW-1:0] REG_VIDEO_TYPE = 3'd4;
	localparam logic [CFG_AW-1:0] REG_VIDEO_PID  = 3'd5;

	localparam logic [7:0] TS_SYNC      = 8'h47;
	localparam logic [7:0] TS_PUSI      = 8'h40;
	localparam logic [7:0] TS_PAYLOAD   = 8'h10;
	localparam logic [7:0] TID_PMT      = 8'h02;
	localparam logic [7:0] SEC_SYNTAX   = 8'hb0;
	localparam logic [7:0] SEC_VERSION  = 8'hc5;
	localparam logic [2:0] RSV3         = 3'b111;
	localparam logic [7:0] RSV_INFO     = 8'hf0;
	localparam logic [7:0] STUFF_BYTE   = 8'hff;
	localparam logic [7:0] SEC_LEN_BASE = 8'd13;
	localparam logic [7:0] ENTRY_BYTES  = 8'd5;

	localparam logic [31:0] CRC_POLY = 32'h04c11db7;
	localparam logic [31:0] CRC_INIT = 32'hffffffff;

	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {b, 24'd0};
		for (int i = 0; i < 8; i++) begin
			r = r[31] ? ({r[30:0], 1'b0} ^ CRC_POLY) : {r[30:0], 1'b0};
		end
		return r;
	endfunction

	function automatic logic is_audio(input logic [ST_W-1:0] t);
		return (t == 8'h03) || (t == 8'h04) || (t == 8'h0f) || (t == 8'h81) || (t == 8'h87);
	endfunction

endpackage

[rtl/ts_psi_packet_generator_core.sv]
`timescale 1ns / 1ps

// PAT/PMT packet generator for a single-program transport stream. Clear and append requests
// edit the elementary stream table. An emit request builds one 188-byte packet and sends it
// as 47 big-endian words, tlast on the final word; a PMT request with an empty table returns
// a single word of zero with tlast and tuser set. Packet bytes are produced one per clock
// while the output register is not stalled and no table read is pending, through a
// byte-serial CRC. A PMT first scans the stored entries for the section length and walks
// the table again during emission (registered table read). Requests are taken one at a
// time; the next one is accepted as soon as the last word sits in the output register.
module ts_psi_packet_generator_core #(
	parameter int MAX_ENTRIES = tspsi_pkg::MAX_ENTRIES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tspsi_pkg::CFG_AW-1:0]  cfg_addr,
	input  logic [tspsi_pkg::CFG_DW-1:0]  cfg_data,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// opcode[1:0], stream_type[9:2], es_pid[22:10], zero[23]
	input  logic [23:0]                   s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// out_word[31:0]
	output logic [31:0]                   m_axis_tdata,
	output logic                          m_axis_tlast,
	// error[0]
	output logic                          m_axis_tuser
);

	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int PW = tspsi_pkg::PID_W;
	localparam int SW = tspsi_pkg::ST_W;
	localparam logic [7:0] LAST_POS = 8'(tspsi_pkg::PACKET_BYTES - 1);
	localparam logic [CW-1:0] FULL = CW'(MAX_ENTRIES);

	typedef enum logic [10:0] {
		ST_IDLE   = 11'b00000000001,
		ST_SFETCH = 11'b00000000010,
		ST_SCHK   = 11'b00000000100,
		ST_HDR    = 11'b00000001000,
		ST_VID    = 11'b00000010000,
		ST_AFETCH = 11'b00000100000,
		ST_ACHK   = 11'b00001000000,
		ST_AUD    = 11'b00010000000,
		ST_CRC    = 11'b00100000000,
		ST_PAD    = 11'b01000000000,
		ST_ERR    = 11'b10000000000
	} state_t;

	state_t state_q;

	logic [15:0]   ts_id_q, program_q;
	logic [PW-1:0] pmt_pid_q, pcr_pid_q, video_pid_q;
	logic [SW-1:0] video_type_q;

	logic [3:0]    pat_cc_q, cc_q;
	logic [CW-1:0] count_q, idx_q;
	logic          is_pmt_q;
	logic [7:0]    sec_len_q, pos_q;
	logic [2:0]    sub_q;
	logic [31:0]   crc_q;
	logic [23:0]   asm_q;
	logic [1:0]    asm_cnt_q;
	logic [SW+PW-1:0] entry_q;

	logic [SW+PW-1:0] es_mem [MAX_ENTRIES];
	logic [SW+PW-1:0] rdata_q;

	logic          out_valid_q, out_last_q, out_err_q;
	logic [31:0]   out_data_q;

	logic [tspsi_pkg::OP_W-1:0] in_op;
	logic [SW-1:0] in_st;
	logic [PW-1:0] in_pid;
	logic          in_req, byte_valid, byte_take, word_done, err_load;
	logic [7:0]    byte_d, hdr_byte, ent_byte;
	logic [SW+PW-1:0] ent_src;
	logic [CW-1:0] idx_inc;

	assign in_op  = s_axis_tdata[1:0];
	assign in_st  = s_axis_tdata[9:2];
	assign in_pid = s_axis_tdata[22:10];
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_req  = s_axis_tvalid && s_axis_tready;
	assign idx_inc = idx_q + CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_id_q      <= '0;
			program_q    <= 16'd1;
			pmt_pid_q    <= 13'd256;
			pcr_pid_q    <= 13'd8191;
			video_type_q <= '0;
			video_pid_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				tspsi_pkg::REG_TS_ID:      ts_id_q      <= cfg_data;
				tspsi_pkg::REG_PROGRAM:    program_q    <= cfg_data;
				tspsi_pkg::REG_PMT_PID:    pmt_pid_q    <= cfg_data[PW-1:0];
				tspsi_pkg::REG_PCR_PID:    pcr_pid_q    <= cfg_data[PW-1:0];
				tspsi_pkg::REG_VIDEO_TYPE: video_type_q <= cfg_data[SW-1:0];
				tspsi_pkg::REG_VIDEO_PID:  video_pid_q  <= cfg_data[PW-1:0];
				default: ;
			endcase
		end
	end

	// table memory, written only while idle
	always_ff @(posedge clk) begin
		if (in_req && in_op == tspsi_pkg::OP_APPEND && count_q < FULL) begin
			es_mem[count_q[AW-1:0]] <= {in_st, in_pid};
		end
		rdata_q <= es_mem[idx_q[AW-1:0]];
	end

	always_comb begin
		hdr_byte = 8'h00;
		case (pos_q)
			8'd0:  hdr_byte = tspsi_pkg::TS_SYNC;
			8'd1:  hdr_byte = is_pmt_q ? {3'b010, pmt_pid_q[12:8]} : tspsi_pkg::TS_PUSI;
			8'd2:  hdr_byte = is_pmt_q ? pmt_pid_q[7:0] : 8'h00;
			8'd3:  hdr_byte = tspsi_pkg::TS_PAYLOAD | {4'd0, cc_q};
			8'd5:  hdr_byte = is_pmt_q ? tspsi_pkg::TID_PMT : 8'h00;
			8'd6:  hdr_byte = tspsi_pkg::SEC_SYNTAX;
			8'd7:  hdr_byte = sec_len_q;
			8'd8:  hdr_byte = is_pmt_q ? program_q[15:8] : ts_id_q[15:8];
			8'd9:  hdr_byte = is_pmt_q ? program_q[7:0] : ts_id_q[7:0];
			8'd10: hdr_byte = tspsi_pkg::SEC_VERSION;
			8'd13: hdr_byte = is_pmt_q ? {tspsi_pkg::RSV3, pcr_pid_q[12:8]} : program_q[15:8];
			8'd14: hdr_byte = is_pmt_q ? pcr_pid_q[7:0] : program_q[7:0];
			8'd15: hdr_byte = is_pmt_q ? tspsi_pkg::RSV_INFO : {tspsi_pkg::RSV3, pmt_pid_q[12:8]};
			8'd16: hdr_byte = is_pmt_q ? 8'h00 : pmt_pid_q[7:0];
			default: hdr_byte = 8'h00;
		endcase
	end

	assign ent_src = (state_q == ST_VID) ? {video_type_q, video_pid_q} : entry_q;

	always_comb begin
		ent_byte = 8'h00;
		case (sub_q)
			3'd0: ent_byte = ent_src[SW+PW-1:PW];
			3'd1: ent_byte = {tspsi_pkg::RSV3, ent_src[12:8]};
			3'd2: ent_byte = ent_src[7:0];
			3'd3: ent_byte = tspsi_pkg::RSV_INFO;
			default: ent_byte = 8'h00;
		endcase
	end

	always_comb begin
		byte_valid = 1'b1;
		byte_d     = tspsi_pkg::STUFF_BYTE;
		case (state_q)
			ST_HDR:  byte_d = hdr_byte;
			ST_VID:  byte_d = ent_byte;
			ST_AUD:  byte_d = ent_byte;
			ST_CRC:  byte_d = crc_q[31 - 8 * sub_q[1:0] -: 8];
			ST_PAD:  byte_d = tspsi_pkg::STUFF_BYTE;
			default: byte_valid = 1'b0;
		endcase
	end

	assign byte_take = byte_valid && !(asm_cnt_q == 2'd3 && out_valid_q && !m_axis_tready);
	assign word_done = byte_take && asm_cnt_q == 2'd3;
	assign err_load  = (state_q == ST_ERR) && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pat_cc_q  <= '0;
			count_q   <= '0;
			idx_q     <= '0;
			pos_q     <= '0;
			sub_q     <= '0;
			asm_cnt_q <= '0;
		end else begin
			if (byte_take) begin
				pos_q     <= pos_q + 8'd1;
				asm_cnt_q <= asm_cnt_q + 2'd1;
			end
			case (state_q)
				ST_IDLE: begin
					pos_q <= '0;
					idx_q <= '0;
					sub_q <= '0;
					if (in_req) begin
						case (in_op)
							tspsi_pkg::OP_CLEAR: count_q <= '0;
							tspsi_pkg::OP_APPEND: begin
								if (count_q < FULL) count_q <= count_q + CW'(1);
							end
							tspsi_pkg::OP_PAT: begin
								pat_cc_q <= pat_cc_q + 4'd1;
								state_q  <= ST_HDR;
							end
							default: state_q <= (count_q == '0) ? ST_ERR : ST_SFETCH;
						endcase
					end
				end
				ST_SFETCH: state_q <= ST_SCHK;
				ST_SCHK: begin
					if (idx_inc == count_q) begin
						idx_q   <= '0;
						state_q <= ST_HDR;
					end else begin
						idx_q   <= idx_inc;
						state_q <= ST_SFETCH;
					end
				end
				ST_HDR: begin
					if (byte_take && pos_q == 8'd16) begin
						if (!is_pmt_q) state_q <= ST_CRC;
						else if (video_type_q != '0) state_q <= ST_VID;
						else state_q <= ST_AFETCH;
					end
				end
				ST_VID: begin
					if (byte_take) begin
						if (sub_q == 3'd4) begin
							sub_q   <= '0;
							state_q <= ST_AFETCH;
						end else begin
							sub_q <= sub_q + 3'd1;
						end
					end
				end
				ST_AFETCH: state_q <= ST_ACHK;
				ST_ACHK: begin
					idx_q <= idx_inc;
					if (tspsi_pkg::is_audio(rdata_q[SW+PW-1:PW])) state_q <= ST_AUD;
					else if (idx_inc == count_q) state_q <= ST_CRC;
					else state_q <= ST_AFETCH;
				end
				ST_AUD: begin
					if (byte_take) begin
						if (sub_q == 3'd4) begin
							sub_q   <= '0;
							state_q <= (idx_q == count_q) ? ST_CRC : ST_AFETCH;
						end else begin
							sub_q <= sub_q + 3'd1;
						end
					end
				end
				ST_CRC: begin
					if (byte_take) begin
						if (sub_q == 3'd3) begin
							sub_q   <= '0;
							state_q <= ST_PAD;
						end else begin
							sub_q <= sub_q + 3'd1;
						end
					end
				end
				ST_PAD: begin
					if (byte_take && pos_q == LAST_POS) state_q <= ST_IDLE;
				end
				ST_ERR: begin
					if (err_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// per-request payload state
	always_ff @(posedge clk) begin
		if (in_req) begin
			is_pmt_q  <= (in_op == tspsi_pkg::OP_PMT);
			cc_q      <= (in_op == tspsi_pkg::OP_PMT) ? 4'd0 : pat_cc_q;
			sec_len_q <= (in_op == tspsi_pkg::OP_PMT && video_type_q != '0) ?
				tspsi_pkg::SEC_LEN_BASE + tspsi_pkg::ENTRY_BYTES : tspsi_pkg::SEC_LEN_BASE;
			crc_q     <= tspsi_pkg::CRC_INIT;
		end else begin
			if (state_q == ST_SCHK && tspsi_pkg::is_audio(rdata_q[SW+PW-1:PW])) begin
				sec_len_q <= sec_len_q + tspsi_pkg::ENTRY_BYTES;
			end
			// section bytes from table id up to the last entry feed the crc
			if (byte_take && ((state_q == ST_HDR && pos_q >= 8'd5) ||
					state_q == ST_VID || state_q == ST_AUD)) begin
				crc_q <= tspsi_pkg::crc_byte(crc_q, byte_d);
			end
		end
		if (state_q == ST_ACHK) entry_q <= rdata_q;
		if (byte_take) asm_q <= {asm_q[15:0], byte_d};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (word_done || err_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (word_done) begin
			out_data_q <= {asm_q, byte_d};
			out_last_q <= (pos_q == LAST_POS);
			out_err_q  <= 1'b0;
		end else if (err_load) begin
			out_data_q <= '0;
			out_last_q <= 1'b1;
			out_err_q  <= 1'b1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_err_q;

endmodule

[rtl/tspsi_checker.sv]
`timescale 1ns / 1ps

module tspsi_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [23:0] s_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tlast,
	input logic        m_axis_tuser
);

	logic in_acc;
	assign in_acc = s_axis_tvalid && s_axis_tready;

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
			$stable(m_axis_tuser))
		else $error("stalled result changed");

	// error result is a single zero word closing the request
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata == 32'd0)
		else $error("malformed error result");

	// table edits never block the next request
	a_edit: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (s_axis_tdata[1:0] == tspsi_pkg::OP_CLEAR ||
			s_axis_tdata[1:0] == tspsi_pkg::OP_APPEND) |=> s_axis_tready)
		else $error("busy after table edit");

	// a pat request keeps the input busy while the packet is built
	a_pat: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && s_axis_tdata[1:0] == tspsi_pkg::OP_PAT |=> !s_axis_tready)
		else $error("pat request not taken up");

endmodule

bind ts_psi_packet_generator_core tspsi_checker u_tspsi_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import tspsi_pkg::*;

	localparam int WORDS_PER_PACKET = PACKET_BYTES / 4;
	localparam int STALL_LIMIT      = 5000;
	localparam int SETTLE_CYCLES    = 400;
	localparam logic [7:0] AUDIO_TYPES [5] = '{8'h03, 8'h04, 8'h0f, 8'h81, 8'h87};

	typedef struct packed {
		logic [31:0] word;
		logic        last;
		logic        err_flag;
	} ts_word_t;

	class psi_packet_scoreboard;
		logic [15:0] ts_id;
		logic [15:0] program_number;
		logic [12:0] pmt_pid;
		logic [12:0] pcr_pid;
		logic [7:0]  video_type;
		logic [12:0] video_pid;
		logic [3:0]  pat_cc;
		logic [7:0]  entry_type [MAX_ENTRIES];
		logic [12:0] entry_pid [MAX_ENTRIES];
		int unsigned entry_count;
		logic [7:0]  pkt [PACKET_BYTES];
		ts_word_t    expected_words [$];
		int          errors;

		function new();
			ts_id          = 16'd0;
			program_number = 16'd1;
			pmt_pid        = 13'd256;
			pcr_pid        = 13'd8191;
			video_type     = 8'd0;
			video_pid      = 13'd0;
			pat_cc         = 4'd0;
			entry_count    = 0;
			errors         = 0;
		endfunction

		function void set_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
			case (idx)
			REG_TS_ID: begin
				ts_id = val;
			end
			REG_PROGRAM: begin
				program_number = val;
			end
			REG_PMT_PID: begin
				pmt_pid = val[12:0];
			end
			REG_PCR_PID: begin
				pcr_pid = val[12:0];
			end
			REG_VIDEO_TYPE: begin
				video_type = val[7:0];
			end
			REG_VIDEO_PID: begin
				video_pid = val[12:0];
			end
			default: begin
			end
			endcase
		endfunction

		function bit audio_type(logic [7:0] t);
			case (t)
			8'h03, 8'h04, 8'h0f, 8'h81, 8'h87: return 1'b1;
			default: return 1'b0;
			endcase
		endfunction

		function int put_entry(int at, logic [7:0] t, logic [12:0] pid);
			pkt[at]     = t;
			pkt[at + 1] = {3'b111, pid[12:8]};
			pkt[at + 2] = pid[7:0];
			pkt[at + 3] = 8'hf0;
			pkt[at + 4] = 8'h00;
			return at + 5;
		endfunction

		// section crc: msb first, no reflection, no final xor
		function logic [31:0] section_crc(int stop);
			logic [31:0] c;
			c = CRC_INIT;
			for (int i = 5; i < stop; i++) begin
				for (int b = 7; b >= 0; b--) begin
					if (c[31] ^ pkt[i][b])
						c = {c[30:0], 1'b0} ^ CRC_POLY;
					else
						c = {c[30:0], 1'b0};
				end
			end
			return c;
		endfunction

		function void seal_packet(int stop);
			logic [31:0] crc;
			ts_word_t    w;
			pkt[7] = 8'(stop - 4);
			crc = section_crc(stop);
			{pkt[stop], pkt[stop + 1], pkt[stop + 2], pkt[stop + 3]} = crc;
			for (int i = stop + 4; i < PACKET_BYTES; i++)
				pkt[i] = 8'hff;
			for (int i = 0; i < WORDS_PER_PACKET; i++) begin
				w.word     = {pkt[4 * i], pkt[4 * i + 1], pkt[4 * i + 2], pkt[4 * i + 3]};
				w.last     = (i == WORDS_PER_PACKET - 1);
				w.err_flag = 1'b0;
				expected_words.push_back(w);
			end
		endfunction

		function void build_pat();
			pkt[0]  = 8'h47;
			pkt[1]  = 8'h40;
			pkt[2]  = 8'h00;
			pkt[3]  = {4'h1, pat_cc};
			pat_cc  = pat_cc + 4'd1;
			pkt[4]  = 8'h00;
			pkt[5]  = 8'h00;
			pkt[6]  = 8'hb0;
			pkt[8]  = ts_id[15:8];
			pkt[9]  = ts_id[7:0];
			pkt[10] = 8'hc5;
			pkt[11] = 8'h00;
			pkt[12] = 8'h00;
			pkt[13] = program_number[15:8];
			pkt[14] = program_number[7:0];
			pkt[15] = {3'b111, pmt_pid[12:8]};
			pkt[16] = pmt_pid[7:0];
			seal_packet(17);
		endfunction

		function void build_pmt();
			int       at;
			ts_word_t w;
			if (entry_count == 0) begin
				w.word     = 32'd0;
				w.last     = 1'b1;
				w.err_flag = 1'b1;
				expected_words.push_back(w);
				return;
			end
			pkt[0]  = 8'h47;
			pkt[1]  = {3'b010, pmt_pid[12:8]};
			pkt[2]  = pmt_pid[7:0];
			pkt[3]  = 8'h10;
			pkt[4]  = 8'h00;
			pkt[5]  = 8'h02;
			pkt[6]  = 8'hb0;
			pkt[8]  = program_number[15:8];
			pkt[9]  = program_number[7:0];
			pkt[10] = 8'hc5;
			pkt[11] = 8'h00;
			pkt[12] = 8'h00;
			pkt[13] = {3'b111, pcr_pid[12:8]};
			pkt[14] = pcr_pid[7:0];
			pkt[15] = 8'hf0;
			pkt[16] = 8'h00;
			at = 17;
			if (video_type != 8'd0)
				at = put_entry(at, video_type, video_pid);
			for (int k = 0; k < entry_count; k++) begin
				if (audio_type(entry_type[k]))
					at = put_entry(at, entry_type[k], entry_pid[k]);
			end
			seal_packet(at);
		endfunction

		// returns 0 when the request is dropped (append to a full table)
		function bit note_request(logic [OP_W-1:0] op, logic [7:0] st, logic [12:0] pid);
			case (op)
			OP_CLEAR: begin
				entry_count = 0;
			end
			OP_APPEND: begin
				if (entry_count >= MAX_ENTRIES)
					return 1'b0;
				entry_type[entry_count] = st;
				entry_pid[entry_count]  = pid;
				entry_count++;
			end
			OP_PAT: begin
				build_pat();
			end
			default: begin
				build_pmt();
			end
			endcase
			return 1'b1;
		endfunction

		function void check_word(logic [31:0] word, logic last, logic err_flag);
			ts_word_t want;
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word %h last %b error %b", $time, word, last, err_flag);
				errors++;
				return;
			end
			want = expected_words.pop_front();
			if (want.word !== word || want.last !== last || want.err_flag !== err_flag) begin
				$display("%0t: mismatch: expected word %h last %b error %b, got word %h last %b error %b",
					$time, want.word, want.last, want.err_flag, word, last, err_flag);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [CFG_AW-1:0]  cfg_addr;
	logic [CFG_DW-1:0]  cfg_data;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	logic [23:0]        s_axis_tdata;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [31:0]        m_axis_tdata;
	logic               m_axis_tlast;
	logic               m_axis_tuser;

	psi_packet_scoreboard sb = new();
	int send_idle = 17;
	int recv_idle = 48;
	int items_sent = 0;
	int seq_count = 0;
	int stall_cycles = 0;

	ts_psi_packet_generator_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #1 clk = ~clk;

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_word(m_axis_tdata, m_axis_tlast, m_axis_tuser);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic send_request(logic [OP_W-1:0] op, logic [7:0] st, logic [12:0] pid);
		while ($urandom_range(0, 99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {1'b0, pid, st, op};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (sb.note_request(op, st, pid))
			items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (sb.expected_words.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		sb.set_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic write_all(logic [15:0] ts, logic [15:0] prog, logic [15:0] pmt,
			logic [15:0] pcr, logic [15:0] vtype, logic [15:0] vpid);
		write_reg(REG_TS_ID, ts);
		write_reg(REG_PROGRAM, prog);
		write_reg(REG_PMT_PID, pmt);
		write_reg(REG_PCR_PID, pcr);
		write_reg(REG_VIDEO_TYPE, vtype);
		write_reg(REG_VIDEO_PID, vpid);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [7:0] pick_type();
		case ($urandom_range(0, 3))
		0, 1: return AUDIO_TYPES[$urandom_range(0, 4)];
		2: return 8'($urandom_range(0, 255));
		default: return ($urandom_range(0, 1) != 0) ? 8'h1b : 8'h02;
		endcase
	endfunction

	task automatic run_sequence();
		int n;
		int k;
		seq_count++;
		if ($urandom_range(0, 14) == 0)
			wait_drained();
		// noise request
		if ($urandom_range(0, 7) == 0) begin
			send_request(OP_W'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
				13'($urandom_range(0, 8191)));
			return;
		end
		if ($urandom_range(0, 3) != 0)
			send_request(OP_CLEAR, 8'($urandom_range(0, 255)), 13'($urandom_range(0, 8191)));
		n = (seq_count % 5 == 0) ? $urandom_range(30, 36) : $urandom_range(0, 8);
		for (k = 0; k < n; k++)
			send_request(OP_APPEND, pick_type(), 13'($urandom_range(0, 8191)));
		k = $urandom_range(1, 3);
		repeat (k)
			send_request(($urandom_range(0, 1) != 0) ? OP_PAT : OP_PMT,
				8'($urandom_range(0, 255)), 13'($urandom_range(0, 8191)));
	endtask

	initial begin
		int target;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_addr      = '0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset configuration, empty table
		send_request(OP_PAT, 8'h00, 13'h0000);
		send_request(OP_PMT, 8'hff, 13'h1fff);
		wait_drained();

		// all register bits high, video entry present
		write_all(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
		send_request(OP_PMT, 8'h00, 13'h0000);
		send_request(OP_APPEND, 8'h03, 13'h0000);
		send_request(OP_APPEND, 8'h04, 13'h1fff);
		send_request(OP_APPEND, 8'h00, 13'h0abc);
		send_request(OP_APPEND, 8'hff, 13'h1555);
		send_request(OP_APPEND, 8'h0f, 13'h0aaa);
		send_request(OP_APPEND, 8'h81, 13'h0100);
		send_request(OP_APPEND, 8'h87, 13'h1000);
		send_request(OP_APPEND, 8'h1b, 13'h0042);
		send_request(OP_PMT, 8'h00, 13'h0000);
		send_request(OP_PAT, 8'hff, 13'h1fff);
		wait_drained();

		// all register bits low, no video entry
		write_all(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_request(OP_PMT, 8'h00, 13'h0000);
		send_request(OP_CLEAR, 8'hff, 13'h1fff);
		send_request(OP_PMT, 8'h00, 13'h0000);
		send_request(OP_APPEND, 8'h81, 13'h1555);
		send_request(OP_PMT, 8'h00, 13'h0000);
		send_request(OP_PAT, 8'h00, 13'h0000);

		for (int ph = 0; ph < 3; ph++) begin
			wait_drained();
			send_idle = (ph == 0) ? 17 : (ph == 1) ? 48 : 0;
			recv_idle = (ph == 0) ? 48 : (ph == 1) ? 17 : 0;
			write_all(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
				16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
				($urandom_range(0, 2) == 0) ? 16'h0000 : 16'($urandom_range(0, 65535)),
				16'($urandom_range(0, 65535)));
			target = items_sent + 95;
			while (items_sent < target)
				run_sequence();
		end
		wait_drained();

		if (sb.expected_words.size() != 0) begin
			$display("%0t: %0d expected words never arrived", $time, sb.expected_words.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
